>>> rtl/sfrc_pkg.sv
// shared constants and types for the square-free range counter
// no dependencies; imported by sfrc_mod and square_free_range_count
`default_nettype none

package sfrc_pkg;

    // default sizes handed down from the top level
    localparam int VALUE_BITS_DEF  = 20;
    localparam int SIEVE_DEPTH_DEF = 1024;
    localparam int PRIME_SLOTS_DEF = 256;

    // status of the remainder unit back to the sequencer
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder ready
        logic zero;   // remainder is zero
    } mod_res_t;

endpackage

`default_nettype wire

>>> rtl/square_free_range_count.sv
// top level of the square-free range counter
// depends on sfrc_pkg, sfrc_ram (sieve flags, square table) and sfrc_mod
`default_nettype none

// Counts the values in [range_low, range_high] that no prime square at or
// below the value divides; an empty range (low above high) gives 0 at once.
// One query is worked at a time. Its phases in order, with
// L = min(floor(sqrt(range_high)) + 1, SIEVE_DEPTH - 1):
//   bound search   r stepped up with a running square, no multiply
//   flag clear     sieve entries 0 to L, one sieve entry per cycle
//   sieve          flag of each candidate read and checked; for each prime
//                  its multiples marked, then the marking ended and the square stored
//   count          per value: each square read and compared, a remainder
//                  taken when it is not above the value, then the value closed
// The count phase dominates; it is set by the one-bit-per-cycle remainder
// unit, which runs for each prime square at or below a value until one
// divides it. A new query is accepted once the previous count is in the
// output register, even while that count still waits there unread.
module square_free_range_count
    import sfrc_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int SIEVE_DEPTH = SIEVE_DEPTH_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] range_low,
    input  wire logic [VALUE_BITS-1:0] range_high,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [VALUE_BITS:0]        square_free_count
);

    // sieve index width, square widths and compare width
    localparam int LW    = $clog2(SIEVE_DEPTH);
    localparam int KW    = $clog2(PRIME_SLOTS);
    localparam int TW    = 2 * LW;          // stored square p*p, p < SIEVE_DEPTH
    localparam int SQ_W  = 2 * LW + 1;      // running (r+1)^2, r+1 <= SIEVE_DEPTH
    localparam int CMP_W = (SQ_W > VALUE_BITS) ? SQ_W : VALUE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_CLEAR,
        ST_SV_RD,
        ST_SV_CHK,
        ST_SV_MARK,
        ST_SV_STORE,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_CNT_MOD,
        ST_CNT_NEXT,
        ST_DONE
    } state_t;

    state_t                state_reg;

    // query and sweep registers
    logic [VALUE_BITS-1:0] lo_reg;
    logic [VALUE_BITS-1:0] hi_reg;
    logic [VALUE_BITS-1:0] v_reg;
    logic [LW-1:0]         r_reg;      // bound search root
    logic [SQ_W-1:0]       sqr_reg;    // (r_reg + 1)^2
    logic [LW-1:0]         lim_reg;    // sieve limit
    logic [LW-1:0]         clr_reg;    // flag clear pointer
    logic [LW:0]           p_reg;      // sieve candidate
    logic [LW+1:0]         m_reg;      // multiple being marked
    logic [TW-1:0]         sqp_reg;    // square of the current prime
    logic [KW:0]           total_reg;  // stored squares
    logic [KW:0]           k_reg;      // square being tried
    logic [VALUE_BITS:0]   count_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS:0]   out_count_reg;

    // memory ports
    logic                  flag_we;
    logic [LW-1:0]         flag_waddr;
    logic                  flag_wdata;
    logic                  flag_rdata;
    logic                  tab_we;
    logic [TW-1:0]         tab_rdata;

    // remainder unit
    logic                  mod_start;
    mod_res_t              mod_res;

    // helper terms
    logic [LW:0]           r_inc;
    logic [LW:0]           lim_ext;
    logic [CMP_W-1:0]      s_ext;
    logic [CMP_W-1:0]      v_ext;
    logic                  s_above_v;
    logic                  room;
    logic [TW-1:0]         p_sq;

    assign r_inc     = {1'b0, r_reg} + (LW+1)'(1);
    assign lim_ext   = {1'b0, lim_reg};
    assign s_ext     = CMP_W'(tab_rdata);
    assign v_ext     = CMP_W'(v_reg);
    assign s_above_v = (s_ext > v_ext);
    assign room      = (total_reg < (KW+1)'(PRIME_SLOTS));
    assign p_sq      = TW'(p_reg[LW-1:0]) * TW'(p_reg[LW-1:0]);

    // sieve flag writes: clearing pass, then marking multiples
    always_comb
    begin
        flag_we    = 1'b0;
        flag_waddr = clr_reg;
        flag_wdata = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_waddr = clr_reg;
                flag_wdata = 1'b0;
            end
            ST_SV_MARK:
            begin
                flag_we    = (m_reg <= (LW+2)'(lim_reg));
                flag_waddr = m_reg[LW-1:0];
                flag_wdata = 1'b1;
            end
            default:
            begin
                flag_we = 1'b0;
            end
        endcase
    end

    assign tab_we    = (state_reg == ST_SV_STORE) && room;
    assign mod_start = (state_reg == ST_CNT_CHK) && !s_above_v;

    sfrc_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (p_reg[LW-1:0]),
        .rdata (flag_rdata)
    );

    sfrc_ram #(
        .WIDTH (TW),
        .DEPTH (PRIME_SLOTS)
    ) u_squares (
        .clk   (clk),
        .we    (tab_we),
        .waddr (total_reg[KW-1:0]),
        .wdata (sqp_reg),
        .raddr (k_reg[KW-1:0]),
        .rdata (tab_rdata)
    );

    sfrc_mod #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (v_reg),
        .divisor  (s_ext[VALUE_BITS-1:0]),
        .res      (mod_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            v_reg         <= '0;
            r_reg         <= '0;
            sqr_reg       <= '0;
            lim_reg       <= '0;
            clr_reg       <= '0;
            p_reg         <= '0;
            m_reg         <= '0;
            sqp_reg       <= '0;
            total_reg     <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            // the done state refills the output register itself
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        lo_reg    <= range_low;
                        hi_reg    <= range_high;
                        count_reg <= '0;
                        r_reg     <= '0;
                        sqr_reg   <= SQ_W'(1);
                        // empty range needs no sieve
                        if (range_low > range_high)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_BOUND;
                        end
                    end
                end

                // largest r below the sieve depth with r*r <= high
                ST_BOUND:
                begin
                    if ((r_inc < (LW+1)'(SIEVE_DEPTH)) && (CMP_W'(sqr_reg) <= CMP_W'(hi_reg)))
                    begin
                        r_reg   <= r_inc[LW-1:0];
                        sqr_reg <= sqr_reg + SQ_W'({r_inc, 1'b1});
                    end
                    else
                    begin
                        // limit is r + 1, capped to the last sieve entry
                        if (r_inc == (LW+1)'(SIEVE_DEPTH))
                        begin
                            lim_reg <= LW'(SIEVE_DEPTH - 1);
                        end
                        else
                        begin
                            lim_reg <= r_inc[LW-1:0];
                        end
                        clr_reg   <= '0;
                        state_reg <= ST_CLEAR;
                    end
                end

                ST_CLEAR:
                begin
                    if (clr_reg == lim_reg)
                    begin
                        p_reg     <= (LW+1)'(2);
                        total_reg <= '0;
                        state_reg <= ST_SV_RD;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + LW'(1);
                    end
                end

                // flag of candidate p is read here, seen next cycle
                ST_SV_RD:
                begin
                    if (p_reg > lim_ext)
                    begin
                        v_reg     <= lo_reg;
                        k_reg     <= '0;
                        state_reg <= ST_CNT_RD;
                    end
                    else
                    begin
                        state_reg <= ST_SV_CHK;
                    end
                end

                ST_SV_CHK:
                begin
                    if (flag_rdata)
                    begin
                        p_reg     <= p_reg + (LW+1)'(1);
                        state_reg <= ST_SV_RD;
                    end
                    else
                    begin
                        m_reg     <= {1'b0, p_reg} + {1'b0, p_reg};
                        sqp_reg   <= p_sq;
                        state_reg <= ST_SV_MARK;
                    end
                end

                // one multiple marked per cycle
                ST_SV_MARK:
                begin
                    if (m_reg > (LW+2)'(lim_reg))
                    begin
                        state_reg <= ST_SV_STORE;
                    end
                    else
                    begin
                        m_reg <= m_reg + (LW+2)'(p_reg);
                    end
                end

                // square written through tab_we; dropped when the table is full
                ST_SV_STORE:
                begin
                    if (room)
                    begin
                        total_reg <= total_reg + (KW+1)'(1);
                    end
                    p_reg     <= p_reg + (LW+1)'(1);
                    state_reg <= ST_SV_RD;
                end

                // end of the square list: value counts
                ST_CNT_RD:
                begin
                    if (k_reg == total_reg)
                    begin
                        count_reg <= count_reg + (VALUE_BITS+1)'(1);
                        state_reg <= ST_CNT_NEXT;
                    end
                    else
                    begin
                        state_reg <= ST_CNT_CHK;
                    end
                end

                // square above the value: value counts, else take remainder
                ST_CNT_CHK:
                begin
                    if (s_above_v)
                    begin
                        count_reg <= count_reg + (VALUE_BITS+1)'(1);
                        state_reg <= ST_CNT_NEXT;
                    end
                    else
                    begin
                        state_reg <= ST_CNT_MOD;
                    end
                end

                ST_CNT_MOD:
                begin
                    if (mod_res.done)
                    begin
                        if (mod_res.zero)
                        begin
                            state_reg <= ST_CNT_NEXT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + (KW+1)'(1);
                            state_reg <= ST_CNT_RD;
                        end
                    end
                end

                ST_CNT_NEXT:
                begin
                    if (v_reg == hi_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        v_reg     <= v_reg + VALUE_BITS'(1);
                        k_reg     <= '0;
                        state_reg <= ST_CNT_RD;
                    end
                end

                // hand the count to the output register once it is free
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_count_reg <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign square_free_count = out_count_reg;

endmodule

`default_nettype wire

>>> rtl/sfrc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sfrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sfrc_mod.sv
// iterative remainder unit, one dividend bit per cycle (restoring)
// depends on sfrc_pkg for the status struct
`default_nettype none

module sfrc_mod
    import sfrc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [VALUE_BITS-1:0] divisor,
    output mod_res_t                   res
);

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [VALUE_BITS-1:0] dvd_reg, dvd_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    mod_res_t              res_reg, res_next;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic [VALUE_BITS-1:0] rem_step;

    // shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_reg, dvd_reg[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_step = (trial >= {1'b0, dvs_reg}) ? diff[VALUE_BITS-1:0]
                                                 : trial[VALUE_BITS-1:0];

    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        rem_next      = rem_reg;
        res_next.done = 1'b0;
        res_next.zero = res_reg.zero;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = {dvd_reg[VALUE_BITS-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_BITS - 1))
            begin
                busy_next     = 1'b0;
                res_next.done = 1'b1;
                res_next.zero = (rem_step == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
